// ===== rtl/core/sha256_stream_hasher_top_assert.svh =====
// Assertion macros for the streaming SHA-256 hasher.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sha_pkg.sv =====
// Shared constants, control types and the rotate function for the SHA-256 hasher.
package sha_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef logic [31:0] word_t;

  // Control between sequencer and round unit
  typedef struct packed {
    logic       start;   // load working vars from chaining value
    logic       round;   // perform one round
    logic [5:0] rnd;     // round number
    logic       fold;    // add working vars into chaining value
    logic       reinit;  // chaining value back to H0
  } rnd_ctrl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha_round.sv =====
// Shared SHA-256 round unit: one compression round per cycle, owns the state.
module sha_round
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rnd_ctrl_t   ctrl_i,
  input  word_t       w_i,
  input  logic [2:0]  rd_idx_i,
  output word_t       hash_o
);

  word_t cv_q [8];
  word_t v_q  [8];
  word_t t1, t2;

  // Round arithmetic
  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[ctrl_i.rnd] + w_i;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Working variables
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      v_q <= cv_q;
    end else if (ctrl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= InitHash;
    end else if (ctrl_i.reinit) begin
      cv_q <= InitHash;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
    end
  end

  assign hash_o = cv_q[rd_idx_i];

endmodule

// ===== rtl/core/sha_sched.sv =====
// Message buffer and rolling 16-word schedule window.
module sha_sched
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        wr_i,
  input  logic [5:0]  wr_pos_i,
  input  logic [7:0]  wr_byte_i,
  input  logic        round_i,
  input  logic [5:0]  rnd_i,
  output word_t       w_o
);

  // window held as 16 words; bytes land in it directly, big-endian
  word_t win_q [16];
  word_t w2, w7, w15, w16, wn;
  logic [3:0] ri;

  always_comb begin
    ri  = rnd_i[3:0];
    w2  = win_q[4'(ri - 4'd2)];
    w7  = win_q[4'(ri - 4'd7)];
    w15 = win_q[4'(ri - 4'd15)];
    w16 = win_q[ri];
    wn  = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w7
        + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w16;
    w_o = (rnd_i < 6'd16) ? w16 : wn;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      case (wr_pos_i[1:0])
        2'd0:    win_q[wr_pos_i[5:2]][31:24] <= wr_byte_i;
        2'd1:    win_q[wr_pos_i[5:2]][23:16] <= wr_byte_i;
        2'd2:    win_q[wr_pos_i[5:2]][15:8]  <= wr_byte_i;
        default: win_q[wr_pos_i[5:2]][7:0]   <= wr_byte_i;
      endcase
    end else if (round_i && rnd_i >= 6'd16) begin
      win_q[ri] <= wn;
    end
  end

endmodule

// ===== rtl/core/sha256_stream_hasher_top.sv =====
// Streaming SHA-256 hasher top level: byte intake, padding sequencer, digest output.
// Usage: absorb bytes (command 0) one per request; finish (command 1) pads the
// message and emits eight digest words, index 0 first, last_word on index 7.
// An absorb request writes one byte, and the 64th byte of a block starts a
// compression (one round per cycle in the shared round unit, then a fold).
// A finish takes the zero fill up to byte 56 (one byte per cycle), the eight length
// bytes and a compression (two compressions plus a fill of 64 when 56 or more
// bytes are pending), then eight output words. in_stall_o is high throughout.
`include "sha256_stream_hasher_top_assert.svh"
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StFold = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [60:0] cnt_q, cnt_d;
  logic [5:0]  pos_q, pos_d;     // fill position during padding
  logic [6:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;     // finishing message
  logic        lenblk_q, lenblk_d; // current pad block carries the length
  logic [2:0]  oidx_q, oidx_d;
  logic        ovld_q, ovld_d;
  logic        accept;
  logic        wr;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [63:0] bits;
  rnd_ctrl_t   ctrl;
  word_t       w, hash;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign bits       = {cnt_q, 3'b000};

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    rnd_d    = rnd_q;
    fin_d    = fin_q;
    lenblk_d = lenblk_q;
    oidx_d   = oidx_q;
    ovld_d   = ovld_q;
    wr       = 1'b0;
    wr_pos   = pos_q;
    wr_byte  = 8'h00;
    ctrl     = '0;
    ctrl.rnd = rnd_q[5:0];
    case (state_q)
      StIdle: begin
        if (accept) begin
          wr     = 1'b1;
          wr_pos = cnt_q[5:0];
          if (!command_i) begin
            wr_byte = data_byte_i;
            cnt_d   = cnt_q + 61'd1;
            if (cnt_q[5:0] == 6'd63) begin
              ctrl.start = 1'b1;
              rnd_d      = '0;
              fin_d      = 1'b0;
              state_d    = StComp;
            end
          end else begin
            wr_byte  = PadByte;
            fin_d    = 1'b1;
            lenblk_d = (cnt_q[5:0] < LenPos);
            pos_d    = cnt_q[5:0] + 6'd1;
            state_d  = StPad;
            if (cnt_q[5:0] == 6'd63) begin
              ctrl.start = 1'b1;
              rnd_d      = '0;
              state_d    = StComp;
            end
          end
        end
      end
      StPad: begin
        wr = 1'b1;
        if (lenblk_q && pos_q >= LenPos) begin
          wr_byte = bits[63 - 8 * (32'(pos_q) - 56) -: 8];
        end
        pos_d = pos_q + 6'd1;
        if (pos_q == 6'd63) begin
          ctrl.start = 1'b1;
          rnd_d      = '0;
          state_d    = StComp;
        end
      end
      StComp: begin
        ctrl.round = 1'b1;
        rnd_d      = rnd_q + 7'd1;
        if (rnd_q == 7'd63) state_d = StFold;
      end
      StFold: begin
        ctrl.fold = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (!lenblk_q) begin
          lenblk_d = 1'b1;
          pos_d    = '0;
          state_d  = StPad;
        end else begin
          oidx_d  = '0;
          ovld_d  = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ovld_d      = 1'b0;
            ctrl.reinit = 1'b1;
            cnt_d       = '0;
            fin_d       = 1'b0;
            state_d     = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      pos_q    <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      rnd_q    <= rnd_d;
      fin_q    <= fin_d;
      lenblk_q <= lenblk_d;
      oidx_q   <= oidx_d;
      ovld_q   <= ovld_d;
    end
  end

  sha_sched u_sched (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_pos_i  (wr_pos),
    .wr_byte_i (wr_byte),
    .round_i   (ctrl.round),
    .rnd_i     (rnd_q[5:0]),
    .w_o       (w)
  );

  sha_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .w_i      (w),
    .rd_idx_i (oidx_q),
    .hash_o   (hash)
  );

  assign out_valid_o   = ovld_q;
  assign digest_word_o = hash;
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  `SHA_ASSERT_IMP(a_out_only_in_out, out_valid_o, state_q == StOut, "output valid outside output phase")
  `SHA_ASSERT_IMP(a_busy_stall, state_q != StIdle, in_stall_o, "input taken while busy")
  `SHA_ASSERT_NEXT(a_last_done, out_valid_o && last_word_o && !out_stall_i, state_q == StIdle && cnt_q == '0, "no return to initial state after digest")
  `SHA_ASSERT_IMP(a_round_range, state_q == StComp, rnd_q < 7'd64, "round counter out of range")

endmodule

// ===== sim/sha256_stream_hasher_top_test.sv =====
// Testbench for the streaming SHA-256 hasher: random byte messages checked against a digest predictor.
`timescale 1ns / 100ps
module sha256_stream_hasher_top_test
  import sha_pkg::*;
;

  typedef enum logic {CmdAbsorb = 1'b0, CmdFinish = 1'b1} cmd_e;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
    bit         drain;  // hold this request until every digest word is back
  } byte_req_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam int TotalReqs = 330;
  localparam int StallLimit = 5000;
  localparam int LongHold = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  byte_req_t    pending_q[$];
  digest_word_t digest_q[$];
  byte_req_t    cur_req;
  int           sent_reqs = 0;
  int           errors = 0;
  int           quiet_cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  // predictor state
  logic [31:0] chain_h[8];
  logic [7:0]  msg_buf[64];
  logic [60:0] msg_len;

  sha256_stream_hasher_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_buf into chain_h
  function automatic void compress_buf();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  // absorb a byte or finish the message, queueing digest words
  function automatic void hash_request(input byte_req_t r);
    int unsigned pos;
    logic [63:0] bits;
    digest_word_t dw;
    pos = msg_len[5:0];
    if (r.cmd == CmdAbsorb) begin
      msg_buf[pos] = r.data;
      msg_len = msg_len + 61'd1;
      if (pos == 63) compress_buf();
      return;
    end
    msg_buf[pos] = PadByte;
    for (int i = pos + 1; i < 64; i++) msg_buf[i] = 8'h00;
    if (pos >= LenPos) begin
      compress_buf();
      for (int i = 0; i < 64; i++) msg_buf[i] = 8'h00;
    end
    bits = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) msg_buf[56+i] = bits[63-8*i -: 8];
    compress_buf();
    for (int i = 0; i < 8; i++) begin
      dw.word = chain_h[i];
      dw.index = i[2:0];
      dw.last = (i == 7);
      digest_q.push_back(dw);
    end
    chain_h = InitHash;
    msg_len = '0;
  endfunction

  task automatic add_message(input int len, input bit drain);
    byte_req_t r;
    for (int i = 0; i < len; i++) begin
      r.cmd = CmdAbsorb;
      r.data = 8'($urandom_range(0, 255));
      r.drain = drain && (i == 0);
      pending_q.push_back(r);
    end
    r.cmd = CmdFinish;
    r.data = 8'($urandom_range(0, 255));
    r.drain = drain && (len == 0);
    pending_q.push_back(r);
  endtask

  task automatic add_bytes(input logic [7:0] b);
    byte_req_t r;
    r.cmd = CmdAbsorb;
    r.data = b;
    r.drain = 1'b0;
    pending_q.push_back(r);
  endtask

  // idle percentages per quarter of the run
  function automatic int tx_idle_pct();
    case (sent_reqs * 4 / TotalReqs)
      1: return 60;
      3: return 35;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct();
    case (sent_reqs * 4 / TotalReqs)
      2: return 60;
      3: return 35;
      default: return 0;
    endcase
  endfunction

  // request driver
  always @(posedge clk_i) begin
    bit nv;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        hash_request(cur_req);
        sent_reqs++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        nv = 1'b0;
        if (pending_q.size() > 0 && !(pending_q[0].drain && digest_q.size() > 0)
            && $urandom_range(0, 99) >= tx_idle_pct()) begin
          cur_req = pending_q.pop_front();
          command_i <= cur_req.cmd;
          data_byte_i <= cur_req.data;
          nv = 1'b1;
        end
        in_valid_i <= nv;
      end
    end
  end

  // receiver stall, with one long hold-off early in the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && sent_reqs >= 40) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct());
      end
    end
  end

  // digest monitor and watchdog
  always @(posedge clk_i) begin
    digest_word_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d", $time, digest_word_o,
                   word_index_o);
          errors++;
        end else begin
          e = digest_q.pop_front();
          if (digest_word_o !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, digest_word_o);
            errors++;
          end
          if (word_index_o !== e.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.index, word_index_o);
            errors++;
          end
          if (last_word_o !== e.last) begin
            $display("%0t: last_word expected %0b actual %0b", $time, e.last, last_word_o);
            errors++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int lens[7] = '{55, 56, 57, 63, 64, 65, 119};
    chain_h = InitHash;
    msg_len = '0;
    // directed: empty message, extreme bytes, back-to-back finishes
    add_message(0, 1'b0);
    add_bytes(8'h00);
    add_bytes(8'hff);
    add_bytes(8'h61);
    add_bytes(8'h80);
    add_message(0, 1'b0);
    add_message(0, 1'b1);
    add_message(1, 1'b0);
    // random messages, lengths around the padding boundaries too
    while (pending_q.size() < TotalReqs) begin
      if ($urandom_range(0, 99) < 75) len = $urandom_range(0, 12);
      else len = lens[$urandom_range(0, 6)];
      add_message(len, $urandom_range(0, 4) == 0);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() > 0 || in_valid_i || digest_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
